// ===== rtl/core/pprrs_pkg.sv =====
// Shared constants and codes for the priority round-robin scheduler.
`default_nettype none
package pprrs_pkg;
    localparam int MAX_TASKS = 16;
    localparam int ID_W      = 4;
    localparam int ID_SPACE  = 1 << ID_W;
    localparam int POS_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int PRIO_W    = 8;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 16;
    localparam int SLICE_W   = 8;

    localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd10;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_TICK   = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/core/preemptive_priority_rr_scheduler.sv =====
// Top level: command-driven preemptive priority scheduler with round-robin.
//
// One request is taken when start is high and busy is low. An arrival request
// completes without raising busy; its result strobes on o_valid the next
// cycle. A tick request is worked by a small sequencer that walks the ready
// queue one entry per cycle through a single priority compare unit: up to
// three queue scans (preemption, round-robin, successor after a finish), up to
// three one-place queue shifts and one wait-accrual sweep. Busy stays high
// while the sequencer runs; the tick result strobes in the same cycle that busy
// drops. Each result is on the output ports for exactly one cycle with o_valid
// high; the receiver cannot stall it, so capture it on that cycle. The quantum
// register may be written only while busy is low.
`default_nettype none
module preemptive_priority_rr_scheduler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_cfg_we,
    input  wire logic [pprrs_pkg::SLICE_W-1:0]  i_cfg_wdata,
    input  wire logic                           i_command,
    input  wire logic [pprrs_pkg::ID_W-1:0]     i_task_id,
    input  wire logic [pprrs_pkg::PRIO_W-1:0]   i_task_priority,
    input  wire logic [pprrs_pkg::BURST_W-1:0]  i_task_burst,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic [pprrs_pkg::TIME_W-1:0]        o_now_time,
    output logic                                o_busy_res,
    output logic [pprrs_pkg::ID_W-1:0]          o_running_id,
    output logic                                o_finished_valid,
    output logic [pprrs_pkg::ID_W-1:0]          o_finished_id,
    output logic [pprrs_pkg::TIME_W-1:0]        o_turnaround,
    output logic [pprrs_pkg::TIME_W-1:0]        o_wait_ticks
);
    import pprrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_RRCHK, S_WAIT, S_DEC, S_OUT
    } t_state;

    // What the current scan is for
    typedef enum logic [1:0] {C_PREEMPT, C_RR, C_FINISH} t_ctx;

    t_state r_state;
    t_ctx   r_ctx;

    logic [SLICE_W-1:0] r_quantum;
    logic [TIME_W-1:0]  r_tick;
    logic               r_run_valid;
    logic [ID_W-1:0]    r_run_task;
    logic [PRIO_W-1:0]  r_run_prio;
    logic [SLICE_W-1:0] r_slice;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;

    // Scan results
    logic               r_found;
    logic [POS_W-1:0]   r_pos;
    logic [ID_W-1:0]    r_cand;
    logic [PRIO_W-1:0]  r_best_prio;

    // Queue order and per-id stores; undefined until written
    logic [ID_W-1:0]    r_order   [MAX_TASKS];
    logic [PRIO_W-1:0]  r_prio    [ID_SPACE];
    logic [BURST_W-1:0] r_remain  [ID_SPACE];
    logic [TIME_W-1:0]  r_arrival [ID_SPACE];
    logic [TIME_W-1:0]  r_wait    [ID_SPACE];
    logic [ID_SPACE-1:0] r_active;

    // Finish report held for the tick result
    logic               r_fin_valid;
    logic [ID_W-1:0]    r_fin_id;
    logic [TIME_W-1:0]  r_fin_turn;
    logic [TIME_W-1:0]  r_fin_wait;

    // Queue walk port: one entry per cycle
    logic [POS_W-1:0]   w_pos;
    logic [POS_W-1:0]   w_pos_nxt;
    logic [ID_W-1:0]    w_qid;
    logic [PRIO_W-1:0]  w_qprio;
    logic [BURST_W-1:0] w_rem;
    logic [BURST_W-1:0] w_rem_dec;
    logic [TIME_W:0]    w_turn;
    logic [CNT_W-1:0]   w_last;

    assign w_pos     = r_idx[POS_W-1:0];
    assign w_pos_nxt = w_pos + POS_W'(1);
    assign w_qid     = r_order[w_pos];
    assign w_qprio   = r_prio[w_qid];
    assign w_rem     = r_remain[r_run_task];
    assign w_rem_dec = (w_rem != '0) ? w_rem - BURST_W'(1) : '0;
    assign w_turn    = {1'b0, r_tick} - {1'b0, r_arrival[r_run_task]} + (TIME_W+1)'(1);
    assign w_last    = r_count - CNT_W'(1);

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ctx       <= C_PREEMPT;
            r_quantum   <= QUANTUM_RESET;
            r_tick      <= '0;
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            r_slice     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_active    <= '0;
            r_found     <= 1'b0;
            o_valid     <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_command == CMD_ARRIVAL) begin
                            o_valid          <= 1'b1;
                            o_now_time       <= r_tick;
                            o_busy_res       <= r_run_valid;
                            o_running_id     <= r_run_valid ? r_run_task : '0;
                            o_finished_valid <= 1'b0;
                            o_finished_id    <= '0;
                            o_turnaround     <= '0;
                            o_wait_ticks     <= '0;
                            if (r_active[i_task_id] || r_count >= CNT_W'(MAX_TASKS)) begin
                                o_status <= ST_REJECT;
                            end else begin
                                o_status                <= ST_ACCEPT;
                                r_active[i_task_id]     <= 1'b1;
                                r_prio[i_task_id]       <= i_task_priority;
                                r_remain[i_task_id]     <= i_task_burst;
                                r_arrival[i_task_id]    <= r_tick;
                                r_wait[i_task_id]       <= '0;
                                r_order[r_count[POS_W-1:0]] <= i_task_id;
                                r_count                 <= r_count + CNT_W'(1);
                            end
                        end else begin
                            r_fin_valid <= 1'b0;
                            r_idx       <= '0;
                            r_found     <= 1'b0;
                            if (r_count != '0) begin
                                r_ctx   <= C_PREEMPT;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_WAIT;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == r_count) begin
                        r_state <= S_DECIDE;
                    end else if (r_ctx == C_RR) begin
                        // first equal-priority task in queue order
                        if (w_qprio == r_run_prio) begin
                            r_found <= 1'b1;
                            r_pos   <= w_pos;
                            r_cand  <= w_qid;
                            r_state <= S_DECIDE;
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        // oldest of highest priority: strict compare keeps first
                        if (!r_found || w_qprio > r_best_prio) begin
                            r_found     <= 1'b1;
                            r_pos       <= w_pos;
                            r_cand      <= w_qid;
                            r_best_prio <= w_qprio;
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_DECIDE: begin
                    r_idx <= CNT_W'(r_pos);
                    unique case (r_ctx)
                        C_PREEMPT: begin
                            if (!r_run_valid || r_best_prio > r_run_prio) begin
                                r_state <= S_SHIFT;
                            end else begin
                                r_state <= S_RRCHK;
                            end
                        end
                        C_RR: begin
                            if (r_found) begin
                                r_state <= S_SHIFT;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_WAIT;
                            end
                        end
                        default: begin
                            r_state <= S_SHIFT;
                        end
                    endcase
                end
                S_SHIFT: begin
                    if (r_idx + CNT_W'(1) < r_count) begin
                        // close the gap one place per cycle
                        r_order[w_pos] <= r_order[w_pos_nxt];
                        r_idx          <= r_idx + CNT_W'(1);
                    end else begin
                        r_slice    <= '0;
                        r_run_task <= r_cand;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        unique case (r_ctx)
                            C_PREEMPT: begin
                                if (r_run_valid) begin
                                    r_order[w_last[POS_W-1:0]] <= r_run_task;
                                end else begin
                                    r_count <= w_last;
                                end
                                r_run_valid <= 1'b1;
                                r_run_prio  <= r_best_prio;
                                r_state     <= S_RRCHK;
                            end
                            C_RR: begin
                                r_order[w_last[POS_W-1:0]] <= r_run_task;
                                r_state <= S_WAIT;
                            end
                            default: begin
                                r_count    <= w_last;
                                r_run_prio <= r_best_prio;
                                r_state    <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RRCHK: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (r_run_valid && r_slice == r_quantum) begin
                        r_ctx   <= C_RR;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (r_idx == r_count) begin
                        r_state <= S_DEC;
                    end else begin
                        if (r_wait[w_qid] != '1) begin
                            r_wait[w_qid] <= r_wait[w_qid] + TIME_W'(1);
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_DEC: begin
                    r_state <= S_OUT;
                    if (r_slice != '1) begin
                        r_slice <= r_slice + SLICE_W'(1);
                    end
                    if (r_run_valid) begin
                        r_remain[r_run_task] <= w_rem_dec;
                        if (w_rem_dec == '0) begin
                            r_fin_valid <= 1'b1;
                            r_fin_id    <= r_run_task;
                            r_fin_turn  <= w_turn[TIME_W] ? '1 : w_turn[TIME_W-1:0];
                            r_fin_wait  <= r_wait[r_run_task];
                            r_active[r_run_task] <= 1'b0;
                            if (r_count != '0) begin
                                r_ctx   <= C_FINISH;
                                r_idx   <= '0;
                                r_found <= 1'b0;
                                r_state <= S_SCAN;
                            end else begin
                                r_run_valid <= 1'b0;
                            end
                        end
                    end
                end
                S_OUT: begin
                    o_valid          <= 1'b1;
                    o_status         <= ST_TICK;
                    o_now_time       <= r_tick;
                    o_busy_res       <= r_run_valid;
                    o_running_id     <= r_run_valid ? r_run_task : '0;
                    o_finished_valid <= r_fin_valid;
                    o_finished_id    <= r_fin_valid ? r_fin_id : '0;
                    o_turnaround     <= r_fin_valid ? r_fin_turn : '0;
                    o_wait_ticks     <= r_fin_valid ? r_fin_wait : '0;
                    if (r_tick != '1) begin
                        r_tick <= r_tick + TIME_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== dv/pprrs_checker.sv =====
// Checker for the scheduler: predicts each result from accepted requests and compares.
`default_nettype none
module pprrs_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic                           i_cfg_we,
    input  wire logic [pprrs_pkg::SLICE_W-1:0]  i_cfg_wdata,
    input  wire logic                           i_command,
    input  wire logic [pprrs_pkg::ID_W-1:0]     i_task_id,
    input  wire logic [pprrs_pkg::PRIO_W-1:0]   i_task_priority,
    input  wire logic [pprrs_pkg::BURST_W-1:0]  i_task_burst,
    input  wire logic                           o_valid,
    input  wire logic [1:0]                     o_status,
    input  wire logic [pprrs_pkg::TIME_W-1:0]   o_now_time,
    input  wire logic                           o_busy_res,
    input  wire logic [pprrs_pkg::ID_W-1:0]     o_running_id,
    input  wire logic                           o_finished_valid,
    input  wire logic [pprrs_pkg::ID_W-1:0]     o_finished_id,
    input  wire logic [pprrs_pkg::TIME_W-1:0]   o_turnaround,
    input  wire logic [pprrs_pkg::TIME_W-1:0]   o_wait_ticks,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pprrs_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [TIME_W-1:0] now_time;
        logic              busy_res;
        logic [ID_W-1:0]   running_id;
        logic              fin_valid;
        logic [ID_W-1:0]   fin_id;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] wait_ticks;
    } t_sched_report;

    t_sched_report report_q[$];

    logic [SLICE_W-1:0] quantum;
    int                 now_tick;
    bit                 running;
    int                 run_id;
    int                 slice;
    int                 ready_q[$];
    int                 prio[ID_SPACE];
    int                 remain[ID_SPACE];
    int                 arrived[ID_SPACE];
    int                 waited[ID_SPACE];
    bit                 active[ID_SPACE];

    assign o_pending = report_q.size();

    function automatic int best_pos();
        int b;
        b = 0;
        for (int i = 1; i < ready_q.size(); i++)
            if (prio[ready_q[i]] > prio[ready_q[b]]) b = i;
        return b;
    endfunction

    function automatic void requeue(int id);
        if (ready_q.size() < MAX_TASKS) ready_q = {ready_q, id};
    endfunction

    function automatic t_sched_report schedule_request(bit cmd, int id, int pr, int bu);
        t_sched_report r;
        int            pos, cand, t;
        r = '0;
        r.now_time = TIME_W'(now_tick);
        if (cmd == CMD_ARRIVAL) begin
            if (active[id] || ready_q.size() >= MAX_TASKS) begin
                r.status = ST_REJECT;
            end else begin
                active[id] = 1; prio[id] = pr; remain[id] = bu;
                arrived[id] = now_tick; waited[id] = 0;
                requeue(id);
                r.status = ST_ACCEPT;
            end
        end else begin
            r.status = ST_TICK;
            if (ready_q.size() > 0) begin
                // preempt on strictly higher priority, or start when idle
                pos = best_pos();
                cand = ready_q[pos];
                if (!running || prio[cand] > prio[run_id]) begin
                    ready_q.delete(pos);
                    if (running) requeue(run_id);
                    run_id = cand; running = 1; slice = 0;
                end
                if (running && slice == quantum) begin
                    for (int i = 0; i < ready_q.size(); i++) begin
                        if (prio[ready_q[i]] == prio[run_id]) begin
                            cand = ready_q[i];
                            ready_q.delete(i);
                            requeue(run_id);
                            run_id = cand; slice = 0;
                            break;
                        end
                    end
                end
            end
            foreach (ready_q[i]) if (waited[ready_q[i]] < 16'hFFFF) waited[ready_q[i]]++;
            if (running && remain[run_id] > 0) remain[run_id]--;
            if (slice < 8'hFF) slice++;
            if (running && remain[run_id] == 0) begin
                r.fin_valid = 1;
                r.fin_id = ID_W'(run_id);
                t = now_tick - arrived[run_id] + 1;
                r.turnaround = (t > 16'hFFFF) ? 16'hFFFF : TIME_W'(t);
                r.wait_ticks = TIME_W'(waited[run_id]);
                active[run_id] = 0;
                if (ready_q.size() > 0) begin
                    slice = 0;
                    pos = best_pos();
                    run_id = ready_q[pos];
                    ready_q.delete(pos);
                end else begin
                    running = 0;
                end
            end
            if (now_tick < 16'hFFFF) now_tick++;
        end
        r.busy_res = running;
        r.running_id = running ? ID_W'(run_id) : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sched_report got, exp_r;
        if (!i_rst_n) begin
            quantum = QUANTUM_RESET; now_tick = 0; running = 0; run_id = 0; slice = 0;
            ready_q.delete(); report_q.delete();
            foreach (active[i]) active[i] = 0;
            o_fail_count <= 0;
        end else begin
            if (o_valid) begin
                got = '{o_status, o_now_time, o_busy_res, o_running_id,
                        o_finished_valid, o_finished_id, o_turnaround, o_wait_ticks};
                if (report_q.size() == 0) begin
                    $error("unexpected result status=%0d", o_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = report_q.pop_front();
                    if (got != exp_r) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.status != exp_r.status)
                            $error("status exp %0d got %0d", exp_r.status, got.status);
                        if (got.now_time != exp_r.now_time)
                            $error("now_time exp %0d got %0d", exp_r.now_time, got.now_time);
                        if (got.busy_res != exp_r.busy_res)
                            $error("busy_res exp %0d got %0d", exp_r.busy_res, got.busy_res);
                        if (got.running_id != exp_r.running_id)
                            $error("running_id exp %0d got %0d",
                                   exp_r.running_id, got.running_id);
                        if (got.fin_valid != exp_r.fin_valid)
                            $error("finished_valid exp %0d got %0d",
                                   exp_r.fin_valid, got.fin_valid);
                        if (got.fin_id != exp_r.fin_id)
                            $error("finished_id exp %0d got %0d", exp_r.fin_id, got.fin_id);
                        if (got.turnaround != exp_r.turnaround)
                            $error("turnaround exp %0d got %0d",
                                   exp_r.turnaround, got.turnaround);
                        if (got.wait_ticks != exp_r.wait_ticks)
                            $error("wait_ticks exp %0d got %0d",
                                   exp_r.wait_ticks, got.wait_ticks);
                    end
                end
            end
            if (i_cfg_we) quantum = i_cfg_wdata;
            if (start && !busy) begin
                exp_r = schedule_request(i_command, i_task_id,
                                         i_task_priority, i_task_burst);
                report_q = {report_q, exp_r};
            end
        end
    end
endmodule
`default_nettype wire

// ===== dv/preemptive_priority_rr_scheduler_tb.sv =====
// Testbench top: drives scheduler requests and quantum writes, reports the verdict.
`default_nettype none
module preemptive_priority_rr_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pprrs_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [SLICE_W-1:0]   i_cfg_wdata = '0;
    logic                 i_command = CMD_TICK;
    logic [ID_W-1:0]      i_task_id = '0;
    logic [PRIO_W-1:0]    i_task_priority = '0;
    logic [BURST_W-1:0]   i_task_burst = '0;
    logic                 o_valid, o_busy_res, o_finished_valid;
    logic [1:0]           o_status;
    logic [TIME_W-1:0]    o_now_time, o_turnaround, o_wait_ticks;
    logic [ID_W-1:0]      o_running_id, o_finished_id;
    int                   fail_count, pending;
    int                   cycle_count = 0;
    bit                   allow_idle;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    preemptive_priority_rr_scheduler uut (.*);

    pprrs_checker checker_i (.*, .o_fail_count(fail_count), .o_pending(pending));

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[preemptive_priority_rr_scheduler] ERROR");
            $finish;
        end
    end

    // Hold the request until the block takes it; start stays high for the next one
    task automatic send_request(bit cmd, int id, int pr, int bu);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_task_id       <= ID_W'(id);
        i_task_priority <= PRIO_W'(pr);
        i_task_burst    <= BURST_W'(bu);
        do @(posedge i_clk); while (busy);
    endtask

    // Write the quantum only once the block has drained
    task automatic set_quantum(int q);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= SLICE_W'(q);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly ticks with a steady trickle of arrivals; short bursts keep tasks finishing
    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 40)
                send_request(CMD_ARRIVAL, $urandom_range(0, 15),
                             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(1, 4),
                             ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12));
            else
                send_request(CMD_TICK, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int qset[6];
        qset = '{1, 255, 0, 2, 3, 7};
        allow_idle = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle tick, extreme fields, duplicate id, zero burst
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_ARRIVAL, 0, 1, 3);
        send_request(CMD_ARRIVAL, 0, 9, 3);
        send_request(CMD_ARRIVAL, 15, 255, 16'hFFFF);
        send_request(CMD_ARRIVAL, 5, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_ARRIVAL, 1, 1, 2);
        send_request(CMD_ARRIVAL, 2, 1, 2);
        repeat (6) send_request(CMD_TICK, 0, 0, 0);
        // Send every id once; ids already queued or running are rejected as duplicates
        for (int i = 0; i < 16; i++) send_request(CMD_ARRIVAL, i, 1, 1);
        repeat (6) send_request(CMD_TICK, 15, 255, 16'hFFFF);

        random_phase(300);
        foreach (qset[k]) begin
            set_quantum(qset[k]);
            random_phase(120);
        end
        set_quantum(QUANTUM_RESET);
        allow_idle = 0;
        random_phase(80);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[preemptive_priority_rr_scheduler] OK");
        end else begin
            $display("[preemptive_priority_rr_scheduler] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
